>>> src/assert_macros.svh
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted
`define SAZ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define SAZ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/saz_pkg.sv
// Types and constants for the six-axis auto-zero offset block
`timescale 1ns / 1ps

package saz_pkg;

	localparam int AXES      = 6;
	localparam int AXIS_W    = 3;
	localparam int RAW_W     = 32;
	localparam int SUM_W     = 48;
	localparam int OUT_W     = 33;
	localparam int CNT_W     = 16;
	localparam int DIV_STEPS = SUM_W;
	localparam int STEP_W    = 6;

	localparam logic [CNT_W-1:0]  ZERO_SAMPLES_RST = CNT_W'(100);
	localparam logic              CMD_REZERO       = 1'b1;
	localparam logic [AXIS_W-1:0] LAST_AXIS        = AXIS_W'(AXES - 1);
	localparam logic [STEP_W-1:0] LAST_STEP        = STEP_W'(DIV_STEPS - 1);

	typedef logic signed [RAW_W-1:0] raw_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [OUT_W-1:0] res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_DLOAD,
		ST_DIV,
		ST_DSTORE,
		ST_SUB,
		ST_OUT
	} state_t;

endpackage

>>> src/six_axis_auto_zero_offset.sv
// Six-axis force/torque tare: offset averaging and offset subtraction
`timescale 1ns / 1ps

// Each accepted word produces exactly one result word. A compensation sample runs six axis
// steps through one shared 33-bit subtractor, then the output load, before the block is
// ready again. A zeroing sample that does not complete the average runs the same steps
// through the shared 48-bit adder instead. A re-zero command clears the sums, offsets and
// sample count and goes straight to the output load. The sample that completes the average
// runs six adder steps, then one shared restoring divider runs 48 quotient steps plus a
// load and a store step once per axis, then the output load. The result sits in an output
// register, so the block may take the next word while the previous result is still waiting
// to be read. The output load waits, and the block stays not ready, for as long as an
// earlier result is still unread.
module six_axis_auto_zero_offset import saz_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cmd,
	input  raw_t             raw_fx,
	input  raw_t             raw_fy,
	input  raw_t             raw_fz,
	input  raw_t             raw_tx,
	input  raw_t             raw_ty,
	input  raw_t             raw_tz,
	output logic             out_valid,
	input  logic             out_ready,
	output res_t             out_fx,
	output res_t             out_fy,
	output res_t             out_fz,
	output res_t             out_tx,
	output res_t             out_ty,
	output res_t             out_tz,
	output logic             zero_done
);

	state_t state_q, state_d;

	logic [AXIS_W-1:0] ax_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  zs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              valid_q;
	logic              done_q;
	logic              neg_q;
	logic [SUM_W-1:0]  dvd_q;
	logic [CNT_W:0]    rem_q;
	logic              out_valid_q;

	raw_t raw_q [AXES];
	sum_t sum_q [AXES];
	raw_t off_q [AXES];
	res_t res_q [AXES];
	res_t out_q [AXES];
	logic out_done_q;

	logic             accept;
	logic             load_out;
	logic [CNT_W-1:0] tgt;
	logic             zeroed_now;
	sum_t             acc_sum;
	sum_t             cur_sum;
	logic [SUM_W-1:0] mag;
	logic [SUM_W-1:0] dvd_init;
	logic [CNT_W:0]   rem_sh;
	logic             fits;
	logic [CNT_W:0]   rem_nx;
	raw_t             quo;
	raw_t             off_v;
	res_t             diff;

	// datapath of the shared unit
	always_comb begin
		tgt        = (zs_q == '0) ? CNT_W'(1) : zs_q;
		zeroed_now = (cnt_q >= tgt);
		cur_sum    = sum_q[ax_q];
		acc_sum    = cur_sum + sum_t'(raw_q[ax_q]);
		mag        = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
		dvd_init   = mag + SUM_W'(cnt_q >> 1);
		rem_sh     = {rem_q[CNT_W-1:0], dvd_q[SUM_W-1]};
		fits       = (rem_sh >= {1'b0, cnt_q});
		rem_nx     = fits ? (rem_sh - {1'b0, cnt_q}) : rem_sh;
		quo        = raw_t'(dvd_q[RAW_W-1:0]);
		off_v      = neg_q ? -quo : quo;
		diff       = res_t'(raw_q[ax_q]) - res_t'(off_q[ax_q]);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (cmd == CMD_REZERO)
						state_d = ST_OUT;
					else if (valid_q)
						state_d = ST_SUB;
					else
						state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				if (ax_q == LAST_AXIS)
					state_d = zeroed_now ? ST_DLOAD : ST_OUT;
			end
			ST_DLOAD:  state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == LAST_STEP)
					state_d = ST_DSTORE;
			end
			ST_DSTORE: state_d = (ax_q == LAST_AXIS) ? ST_OUT : ST_DLOAD;
			ST_SUB: begin
				if (ax_q == LAST_AXIS)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready)
					state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		accept   = in_ready && in_valid;
		load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ax_q        <= '0;
			step_q      <= '0;
			zs_q        <= ZERO_SAMPLES_RST;
			cnt_q       <= '0;
			valid_q     <= 1'b0;
			done_q      <= 1'b0;
			neg_q       <= 1'b0;
			dvd_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < AXES; i++) begin
				sum_q[i] <= '0;
				off_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we)
				zs_q <= cfg_data;

			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ax_q <= '0;
						if (cmd == CMD_REZERO) begin
							cnt_q   <= '0;
							valid_q <= 1'b0;
							done_q  <= 1'b0;
							for (int i = 0; i < AXES; i++) begin
								sum_q[i] <= '0;
								off_q[i] <= '0;
							end
						end else begin
							done_q <= valid_q;
							if (!valid_q && cnt_q != '1)
								cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				ST_ACC: begin
					sum_q[ax_q] <= acc_sum;
					ax_q        <= (ax_q == LAST_AXIS) ? '0 : ax_q + AXIS_W'(1);
				end
				ST_DLOAD: begin
					neg_q  <= cur_sum[SUM_W-1];
					dvd_q  <= dvd_init;
					rem_q  <= '0;
					step_q <= '0;
				end
				ST_DIV: begin
					rem_q  <= rem_nx;
					dvd_q  <= {dvd_q[SUM_W-2:0], fits};
					step_q <= step_q + STEP_W'(1);
				end
				ST_DSTORE: begin
					off_q[ax_q] <= off_v;
					if (ax_q == LAST_AXIS) begin
						ax_q    <= '0;
						valid_q <= 1'b1;
						done_q  <= 1'b1;
					end else begin
						ax_q <= ax_q + AXIS_W'(1);
					end
				end
				ST_SUB: begin
					ax_q <= (ax_q == LAST_AXIS) ? '0 : ax_q + AXIS_W'(1);
				end
				ST_OUT: begin
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			raw_q[0] <= raw_fx;
			raw_q[1] <= raw_fy;
			raw_q[2] <= raw_fz;
			raw_q[3] <= raw_tx;
			raw_q[4] <= raw_ty;
			raw_q[5] <= raw_tz;
			for (int i = 0; i < AXES; i++)
				res_q[i] <= '0;
		end else if (state_q == ST_SUB) begin
			res_q[ax_q] <= diff;
		end
		if (load_out) begin
			for (int i = 0; i < AXES; i++)
				out_q[i] <= res_q[i];
			out_done_q <= done_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_fx    = out_q[0];
	assign out_fy    = out_q[1];
	assign out_fz    = out_q[2];
	assign out_tx    = out_q[3];
	assign out_ty    = out_q[4];
	assign out_tz    = out_q[5];
	assign zero_done = out_done_q;

endmodule

>>> src/saz_checker.sv
// Port-level checks for the six-axis auto-zero offset block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module saz_checker import saz_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input res_t             out_fx,
	input res_t             out_fy,
	input res_t             out_fz,
	input res_t             out_tx,
	input res_t             out_ty,
	input res_t             out_tz,
	input logic             zero_done
);

	logic axes_zero;

	assign axes_zero = (out_fx == '0) && (out_fy == '0) && (out_fz == '0) &&
		(out_tx == '0) && (out_ty == '0) && (out_tz == '0);

	// the cycle after an accept keeps the input side closed while the word is in progress
	`SAZ_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready right after accept")

	// without established offsets every axis reads zero
	`SAZ_ASSERT(a_zero_until_done, out_valid && !zero_done |-> axes_zero, "nonzero axis early")

	`SAZ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

	`SAZ_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_fx) && $stable(out_tz) && $stable(zero_done), "result changed while stalled")

endmodule

bind six_axis_auto_zero_offset saz_checker u_saz_checker (.*);
